/* sv/tpp_pkg.sv */
// Shared types, constants and the Q14 product helper of the torus point projector.
// No dependencies; the projector core imports this package, while tpp_divider does not.
package tpp_pkg;

	typedef enum logic [2:0] {
		REG_TUBE_OFFSET     = 3'd0,
		REG_RING_SCALE      = 3'd1,
		REG_FOCAL_GAIN      = 3'd2,
		REG_VIEWER_DISTANCE = 3'd3,
		REG_CENTER_X        = 3'd4,
		REG_CENTER_Y        = 3'd5
	} reg_index_t;

	localparam logic [11:0] RST_TUBE_OFFSET     = 12'd256;
	localparam logic [11:0] RST_RING_SCALE      = 12'd512;
	localparam logic [9:0]  RST_FOCAL_GAIN      = 10'd150;
	localparam logic [12:0] RST_VIEWER_DISTANCE = 13'd1280;
	localparam logic [10:0] RST_CENTER_X        = 11'd150;
	localparam logic [10:0] RST_CENTER_Y        = 11'd120;

	localparam logic [14:0] POLY_C1 = 15'd25736;
	localparam logic [13:0] POLY_C2 = 14'd10512;
	localparam logic [10:0] POLY_C3 = 11'd1160;
	localparam logic [15:0] PHASE_QUARTER = 16'h4000;

	localparam logic signed [15:0] BRIGHT_GAIN  = 16'sd11469;
	localparam logic signed [35:0] BRIGHT_ROUND = 36'sd8192;

	localparam int DIV_STEPS = 16;
	localparam int NUM_W     = 45;
	localparam int DEN_W     = 31;

	typedef struct packed {
		logic               neg_x;
		logic               neg_y;
		logic               ovf_x;
		logic               ovf_y;
		logic               invalid;
		logic signed [15:0] bright;
	} side_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic signed [15:0] brightness;
		logic               lit;
		logic               depth_invalid;
	} res_t;

	function automatic logic signed [16:0] qm(input logic signed [16:0] a,
		input logic signed [15:0] b);
		logic signed [32:0] p;
		p = a * b;
		return p[30:14];
	endfunction

endpackage

/* sv/torus_point_projector_core.sv */
// Top level of the torus point projector: sine lanes, rotation, projection and output skid.
// Depends on tpp_pkg and tpp_divider.
//
// One surface point enters per clock unless in_stall is high, and its result word reaches
// the output register through 13 stages of sine evaluation, rotation products and
// numerator sums, then the two 16-stage restoring dividers that form the perspective
// quotients, one quotient bit per stage. It sustains one word per cycle unless stalled.
// A two-entry output (register plus skid) keeps the input open while one result waits.
module torus_point_projector_core
	import tpp_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        angle_a,
	input  logic [15:0]        angle_b,
	input  logic [15:0]        theta_phase,
	input  logic [15:0]        phi_phase,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic signed [15:0] brightness,
	output logic               lit,
	output logic               depth_invalid
);

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam logic [16:0] DEPTH_C = 17'(SINE_TABLE_DEPTH);
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << 48) + 64'(SINE_TABLE_DEPTH) - 64'd1) / 64'(SINE_TABLE_DEPTH);
	localparam int RECIP_W = $clog2(RECIP_FULL + 64'd1);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
	localparam int QP_W = IDX_W + RECIP_W;
	localparam int LAT = 13 + DIV_STEPS;

	logic [11:0] tube_offset_q;
	logic [11:0] ring_scale_q;
	logic [9:0]  focal_gain_q;
	logic [12:0] viewer_distance_q;
	logic [10:0] center_x_q;
	logic [10:0] center_y_q;

	logic           adv;
	logic           in_accept;
	logic [LAT:1]   vld_s;
	logic           last_valid;
	logic           out_valid_q;
	logic           skid_full_q;
	res_t           out_q;
	res_t           skid_q;
	res_t           res_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tube_offset_q     <= RST_TUBE_OFFSET;
			ring_scale_q      <= RST_RING_SCALE;
			focal_gain_q      <= RST_FOCAL_GAIN;
			viewer_distance_q <= RST_VIEWER_DISTANCE;
			center_x_q        <= RST_CENTER_X;
			center_y_q        <= RST_CENTER_Y;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TUBE_OFFSET:     tube_offset_q     <= cfg_data[11:0];
				REG_RING_SCALE:      ring_scale_q      <= cfg_data[11:0];
				REG_FOCAL_GAIN:      focal_gain_q      <= cfg_data[9:0];
				REG_VIEWER_DISTANCE: viewer_distance_q <= cfg_data[12:0];
				REG_CENTER_X:        center_x_q        <= cfg_data[10:0];
				REG_CENTER_Y:        center_y_q        <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign adv       = !skid_full_q;
	assign in_stall  = skid_full_q;
	assign in_accept = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], in_accept};
		end
	end

	// Phase quantization and sine evaluation.
	logic [15:0]        phase_in [4];
	logic [15:0]        lane_ph  [8];
	logic signed [15:0] trig     [8];

	assign phase_in[0] = angle_a;
	assign phase_in[1] = angle_b;
	assign phase_in[2] = theta_phase;
	assign phase_in[3] = phi_phase;

	for (genvar g = 0; g < 4; g++) begin : g_quant
		logic [32:0]      iprod;
		logic [QP_W-1:0]  qprod;
		logic [IDX_W-1:0] idx_s1;
		logic [15:0]      q_s2;

		assign iprod = 33'(phase_in[g]) * 33'(DEPTH_C);
		assign qprod = QP_W'(idx_s1) * QP_W'(RECIP);

		always_ff @(posedge clk) begin
			if (adv) begin
				idx_s1 <= iprod[16 +: IDX_W];
				q_s2   <= qprod[32 +: 16];
			end
		end

		assign lane_ph[2*g]   = q_s2;
		assign lane_ph[2*g+1] = q_s2 + PHASE_QUARTER;
	end

	for (genvar g = 0; g < 8; g++) begin : g_sine
		logic [1:0]         quad;
		logic [14:0]        xin;
		logic [29:0]        xx;
		logic [25:0]        c3x2;
		logic [28:0]        tx;
		logic [29:0]        xt;
		logic [14:0]        x_s3, x2_s3, x_s4, x2_s4, x_s5;
		logic [13:0]        t1_s4;
		logic [14:0]        t2_s5;
		logic               neg_s3, neg_s4, neg_s5;
		logic signed [15:0] sin_s6;

		assign quad = lane_ph[g][15:14];
		assign xin  = quad[0] ? (15'd16384 - {1'b0, lane_ph[g][13:0]})
		                      : {1'b0, lane_ph[g][13:0]};
		assign xx   = 30'(xin) * 30'(xin);
		assign c3x2 = 26'(POLY_C3) * 26'(x2_s3);
		assign tx   = 29'(t1_s4) * 29'(x2_s4);
		assign xt   = 30'(x_s5) * 30'(t2_s5);

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s3   <= xin;
				x2_s3  <= xx[28:14];
				neg_s3 <= quad[1];
				x_s4   <= x_s3;
				x2_s4  <= x2_s3;
				t1_s4  <= POLY_C2 - 14'(c3x2[24:14]);
				neg_s4 <= neg_s3;
				x_s5   <= x_s4;
				t2_s5  <= POLY_C1 - tx[28:14];
				neg_s5 <= neg_s4;
				sin_s6 <= neg_s5 ? -$signed(xt[29:14]) : $signed(xt[29:14]);
			end
		end

		assign trig[g] = sin_s6;
	end

	// Rotation, lighting and projection numerators.
	logic signed [15:0] sa, ca, sb, cb, st, ct, sp, cp;
	logic signed [28:0] r2ct, r1st;

	assign sa = trig[0];
	assign ca = trig[1];
	assign sb = trig[2];
	assign cb = trig[3];
	assign st = trig[4];
	assign ct = trig[5];
	assign sp = trig[6];
	assign cp = trig[7];

	assign r2ct = $signed({1'b0, ring_scale_q}) * ct;
	assign r1st = $signed({1'b0, tube_offset_q}) * st;

	logic signed [15:0] m_cbcp_s7, m_sasb_s7, m_sbcp_s7, m_sacb_s7, m_casb_s7, m_cacb_s7;
	logic signed [15:0] m_casp_s7, m_cpct_s7, m_cact_s7, m_sast_s7, m_cast_s7, m_ctsa_s7;
	logic signed [15:0] sa_s7, sb_s7, cb_s7, sp_s7;
	logic signed [13:0] ox_s7, oy_s7;

	logic signed [16:0] kx_s8, ky_s8, dinner_s8;
	logic signed [15:0] la_s8, lb_s8, lc_s8, m_casb_s8, m_cacb_s8, m_casp_s8, sa_s8, cb_s8;
	logic signed [13:0] ox_s8, oy_s8;

	logic signed [31:0] px1_s9, px2_s9, py1_s9, py2_s9, pz1_s9, pz2_s9;
	logic signed [16:0] le_s9;
	logic signed [17:0] lsum_s9;

	logic signed [31:0] x_s10, y_s10, z_s10;
	logic signed [18:0] l_s10;

	logic signed [43:0] cxz_s11, k1x_s11, cyz_s11, k1y_s11;
	logic signed [35:0] bright_p_s11;
	logic signed [31:0] z_s11;
	logic               invalid_s11;

	logic signed [44:0] nx_s12, ny_s12;
	logic signed [15:0] bright_s12;
	logic signed [31:0] z_s12;
	logic               invalid_s12;

	logic [NUM_W-1:0]   num_x_s13, num_y_s13;
	logic [DEN_W-1:0]   den_s13;
	side_t              side_s13;

	logic signed [21:0] bsh;
	logic signed [15:0] bright_sat;
	logic [NUM_W-1:0]   magx, magy;
	logic [DEN_W-1:0]   den_c;
	logic [47:0]        den_top;

	assign bsh = $signed(bright_p_s11[35:14]);
	assign bright_sat = (bsh > 22'sd32767) ? 16'sh7FFF :
	                    (bsh < -22'sd32768) ? 16'sh8000 : bsh[15:0];

	assign magx    = nx_s12[44] ? NUM_W'(-nx_s12) : NUM_W'(nx_s12);
	assign magy    = ny_s12[44] ? NUM_W'(-ny_s12) : NUM_W'(ny_s12);
	assign den_c   = invalid_s12 ? DEN_W'(1) : z_s12[DEN_W-1:0];
	assign den_top = {1'b0, den_c, 16'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			m_cbcp_s7 <= 16'(qm(cb, cp));
			m_sasb_s7 <= 16'(qm(sa, sb));
			m_sbcp_s7 <= 16'(qm(sb, cp));
			m_sacb_s7 <= 16'(qm(sa, cb));
			m_casb_s7 <= 16'(qm(ca, sb));
			m_cacb_s7 <= 16'(qm(ca, cb));
			m_casp_s7 <= 16'(qm(ca, sp));
			m_cpct_s7 <= 16'(qm(cp, ct));
			m_cact_s7 <= 16'(qm(ca, ct));
			m_sast_s7 <= 16'(qm(sa, st));
			m_cast_s7 <= 16'(qm(ca, st));
			m_ctsa_s7 <= 16'(qm(ct, sa));
			sa_s7     <= sa;
			sb_s7     <= sb;
			cb_s7     <= cb;
			sp_s7     <= sp;
			ox_s7     <= $signed({2'b00, tube_offset_q}) + $signed(r2ct[27:14]);
			oy_s7     <= $signed(r1st[27:14]);

			kx_s8     <= 17'(m_cbcp_s7) + qm(m_sasb_s7, sp_s7);
			ky_s8     <= 17'(m_sbcp_s7) - qm(m_sacb_s7, sp_s7);
			dinner_s8 <= 17'(m_cast_s7) - qm(m_ctsa_s7, sp_s7);
			la_s8     <= 16'(qm(m_cpct_s7, sb_s7));
			lb_s8     <= 16'(qm(m_cact_s7, sp_s7));
			lc_s8     <= m_sast_s7;
			m_casb_s8 <= m_casb_s7;
			m_cacb_s8 <= m_cacb_s7;
			m_casp_s8 <= m_casp_s7;
			sa_s8     <= sa_s7;
			cb_s8     <= cb_s7;
			ox_s8     <= ox_s7;
			oy_s8     <= oy_s7;

			px1_s9  <= ox_s8 * kx_s8;
			px2_s9  <= oy_s8 * m_casb_s8;
			py1_s9  <= ox_s8 * ky_s8;
			py2_s9  <= oy_s8 * m_cacb_s8;
			pz1_s9  <= ox_s8 * m_casp_s8;
			pz2_s9  <= oy_s8 * sa_s8;
			le_s9   <= qm(dinner_s8, cb_s8);
			lsum_s9 <= 18'(la_s8) - 18'(lb_s8) - 18'(lc_s8);

			x_s10 <= px1_s9 - px2_s9;
			y_s10 <= py1_s9 + py2_s9;
			z_s10 <= $signed({5'd0, viewer_distance_q, 14'd0}) + pz1_s9 + pz2_s9;
			l_s10 <= 19'(lsum_s9) + 19'(le_s9);

			cxz_s11      <= $signed({1'b0, center_x_q}) * z_s10;
			cyz_s11      <= $signed({1'b0, center_y_q}) * z_s10;
			k1x_s11      <= $signed({1'b0, focal_gain_q}) * x_s10;
			k1y_s11      <= $signed({1'b0, focal_gain_q}) * y_s10;
			bright_p_s11 <= l_s10 * BRIGHT_GAIN + BRIGHT_ROUND;
			z_s11        <= z_s10;
			invalid_s11  <= (z_s10 <= 32'sd0);

			nx_s12      <= 45'(cxz_s11) + 45'(k1x_s11);
			ny_s12      <= 45'(cyz_s11) - 45'(k1y_s11);
			bright_s12  <= bright_sat;
			z_s12       <= z_s11;
			invalid_s12 <= invalid_s11;

			num_x_s13        <= magx;
			num_y_s13        <= magy;
			den_s13          <= den_c;
			side_s13.neg_x   <= nx_s12[44];
			side_s13.neg_y   <= ny_s12[44];
			side_s13.ovf_x   <= (48'(magx) >= den_top);
			side_s13.ovf_y   <= (48'(magy) >= den_top);
			side_s13.invalid <= invalid_s12;
			side_s13.bright  <= bright_s12;
		end
	end

	// Perspective quotients.
	logic [DIV_STEPS-1:0] quo_x, quo_y;
	side_t                side_d [1:DIV_STEPS];

	tpp_divider #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W),
		.QUO_W(DIV_STEPS)
	) u_div_x (
		.clk(clk),
		.en (adv),
		.num(num_x_s13),
		.den(den_s13),
		.quo(quo_x)
	);

	tpp_divider #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W),
		.QUO_W(DIV_STEPS)
	) u_div_y (
		.clk(clk),
		.en (adv),
		.num(num_y_s13),
		.den(den_s13),
		.quo(quo_y)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[1] <= side_s13;
			for (int k = 2; k <= DIV_STEPS; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	side_t side_o;

	assign side_o = side_d[DIV_STEPS];

	always_comb begin
		res_c.brightness    = side_o.bright;
		res_c.depth_invalid = side_o.invalid;
		res_c.lit           = (side_o.bright > 16'sd0) && !side_o.invalid;
		if (side_o.invalid) begin
			res_c.pixel_x = '0;
		end else if (!side_o.neg_x) begin
			res_c.pixel_x = (side_o.ovf_x || quo_x[15]) ? 16'sh7FFF : quo_x;
		end else begin
			res_c.pixel_x = (side_o.ovf_x || (quo_x > 16'h8000)) ? 16'sh8000 : -quo_x;
		end
		if (side_o.invalid) begin
			res_c.pixel_y = '0;
		end else if (!side_o.neg_y) begin
			res_c.pixel_y = (side_o.ovf_y || quo_y[15]) ? 16'sh7FFF : quo_y;
		end else begin
			res_c.pixel_y = (side_o.ovf_y || (quo_y > 16'h8000)) ? 16'sh8000 : -quo_y;
		end
	end

	// Output register with skid entry.
	assign last_valid = vld_s[LAT] && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= last_valid;
			end
		end else if (last_valid) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_full_q ? skid_q : res_c;
		end else if (last_valid) begin
			skid_q <= res_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_x       = out_q.pixel_x;
	assign pixel_y       = out_q.pixel_y;
	assign brightness    = out_q.brightness;
	assign lit           = out_q.lit;
	assign depth_invalid = out_q.depth_invalid;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("Skid entry holds a word while the output register is empty.");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && out_stall |=> skid_full_q)
		else $error("Skid entry dropped a word while the output was stalled.");

	a_invalid_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.depth_invalid |->
			!out_q.lit && out_q.pixel_x == 16'sd0 && out_q.pixel_y == 16'sd0)
		else $error("A word with invalid depth is lit or has nonzero coordinates.");

endmodule

/* sv/tpp_divider.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; the enable freezes every stage together with the caller's pipeline.
module tpp_divider #(
	parameter int NUM_W = 45,
	parameter int DEN_W = 31,
	parameter int QUO_W = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	localparam int RW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

	logic [RW-1:0]    rem_s [1:QUO_W];
	logic [DEN_W-1:0] den_s [1:QUO_W];
	logic [QUO_W-1:0] quo_s [1:QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		logic [RW-1:0]    rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [RW-1:0]    trial;
		logic             fits;

		if (i == 0) begin : g_first
			assign rem_in = RW'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i];
			assign den_in = den_s[i];
			assign quo_in = quo_s[i];
		end

		assign trial = RW'(den_in) << (QUO_W - 1 - i);
		assign fits  = (rem_in >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= fits ? (rem_in - trial) : rem_in;
				den_s[i+1] <= den_in;
				quo_s[i+1] <= {quo_in[QUO_W-2:0], fits};
			end
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

/* test/torus_point_projector_core_tb.sv */
// Testbench of the torus point projector core: directed and random surface points under
// random sender bursts and receiver stalls, checked word by word against its own predictor.
// Depends on tpp_pkg and the torus_point_projector_core RTL.
module torus_point_projector_core_tb;
	import tpp_pkg::*;

	class proj_scoreboard;
		res_t pending[$];
		int errors;
		int checked;

		function void note_point(res_t r);
			pending.push_back(r);
		endfunction

		function void check_word(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word px=%0d py=%0d", $time, got.pixel_x, got.pixel_y);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.pixel_x !== e.pixel_x) begin
				$display("%0t: pixel_x exp %0d got %0d", $time, e.pixel_x, got.pixel_x);
				errors++;
			end
			if (got.pixel_y !== e.pixel_y) begin
				$display("%0t: pixel_y exp %0d got %0d", $time, e.pixel_y, got.pixel_y);
				errors++;
			end
			if (got.brightness !== e.brightness) begin
				$display("%0t: brightness exp %0d got %0d", $time, e.brightness,
					got.brightness);
				errors++;
			end
			if (got.lit !== e.lit) begin
				$display("%0t: lit exp %0b got %0b", $time, e.lit, got.lit);
				errors++;
			end
			if (got.depth_invalid !== e.depth_invalid) begin
				$display("%0t: depth_invalid exp %0b got %0b", $time, e.depth_invalid,
					got.depth_invalid);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = 0;
	logic [12:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [15:0] angle_a = 0, angle_b = 0, theta_phase = 0, phi_phase = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [15:0] pixel_x, pixel_y, brightness;
	logic lit, depth_invalid;

	torus_point_projector_core u_top (.*);

	always #6 clk = ~clk;

	proj_scoreboard sb = new();
	longint r1 = RST_TUBE_OFFSET, r2 = RST_RING_SCALE, k1 = RST_FOCAL_GAIN;
	longint k2 = RST_VIEWER_DISTANCE, cx = RST_CENTER_X, cy = RST_CENTER_Y;
	int stall_mode = 1;
	int n_invalid, n_lit;

	function automatic longint fdiv14(longint v);
		return v >>> 14;
	endfunction

	function automatic longint q14(longint a, longint b);
		return fdiv14(a * b);
	endfunction

	function automatic longint sine_q14(longint p);
		longint quad, f, x, x2, t, s;
		longint i;
		i = ((p & 16'hFFFF) * 1024) >> 16;
		p = ((i << 16) / 1024) & 16'hFFFF;
		quad = (p >> 14) & 3;
		f = p & 16'h3FFF;
		x = quad[0] ? 16384 - f : f;
		x2 = (x * x) >> 14;
		t = 10512 - ((1160 * x2) >> 14);
		t = 25736 - ((t * x2) >> 14);
		s = (x * t) >> 14;
		return quad[1] ? -s : s;
	endfunction

	function automatic longint cosine_q14(longint p);
		longint i, q;
		i = ((p & 16'hFFFF) * 1024) >> 16;
		q = ((i << 16) / 1024) & 16'hFFFF;
		return sine_q14((q + 16384) & 16'hFFFF);
	endfunction

	function automatic longint clamp16(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic res_t project_point(logic [15:0] a, logic [15:0] b,
		logic [15:0] th, logic [15:0] ph);
		longint sa, ca, sbb, cb, st, ct, sp, cp, ox, oy, kx, ky, x, y, z, lum, br;
		longint px, py;
		res_t r;
		sa = sine_q14(a); ca = cosine_q14(a);
		sbb = sine_q14(b); cb = cosine_q14(b);
		st = sine_q14(th); ct = cosine_q14(th);
		sp = sine_q14(ph); cp = cosine_q14(ph);
		ox = r1 + fdiv14(r2 * ct);
		oy = fdiv14(r1 * st);
		kx = q14(cb, cp) + q14(q14(sa, sbb), sp);
		ky = q14(sbb, cp) - q14(q14(sa, cb), sp);
		x = ox * kx - oy * q14(ca, sbb);
		y = ox * ky + oy * q14(ca, cb);
		z = k2 * 16384 + ox * q14(ca, sp) + oy * sa;
		lum = q14(q14(cp, ct), sbb) - q14(q14(ca, ct), sp) - q14(sa, st)
			+ q14(cb, q14(ca, st) - q14(q14(ct, sa), sp));
		br = clamp16(fdiv14(lum * 11469 + 8192));
		px = 0;
		py = 0;
		if (z > 0) begin
			px = clamp16((cx * z + k1 * x) / z);
			py = clamp16((cy * z - k1 * y) / z);
		end
		r.pixel_x = px[15:0];
		r.pixel_y = py[15:0];
		r.brightness = br[15:0];
		r.lit = (br > 0) && (z > 0);
		r.depth_invalid = (z <= 0);
		return r;
	endfunction

	task automatic write_reg(reg_index_t idx, int val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 13'(val);
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_TUBE_OFFSET:     r1 = val & 12'hFFF;
			REG_RING_SCALE:      r2 = val & 12'hFFF;
			REG_FOCAL_GAIN:      k1 = val & 10'h3FF;
			REG_VIEWER_DISTANCE: k2 = val & 13'h1FFF;
			REG_CENTER_X:        cx = val & 11'h7FF;
			REG_CENTER_Y:        cy = val & 11'h7FF;
			default: ;
		endcase
	endtask

	task automatic apply_setting(int a, int b, int c, int d, int e, int f);
		write_reg(REG_TUBE_OFFSET, a);
		write_reg(REG_RING_SCALE, b);
		write_reg(REG_FOCAL_GAIN, c);
		write_reg(REG_VIEWER_DISTANCE, d);
		write_reg(REG_CENTER_X, e);
		write_reg(REG_CENTER_Y, f);
	endtask

	task automatic send_point(logic [15:0] a, logic [15:0] b, logic [15:0] th,
		logic [15:0] ph);
		in_valid <= 1;
		angle_a <= a;
		angle_b <= b;
		theta_phase <= th;
		phi_phase <= ph;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_point(project_point(a, b, th, ph));
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_run(int count);
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
				burst = $urandom_range(1, 30);
			end
			burst--;
			send_point(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sb.check_word('{pixel_x, pixel_y, brightness, lit, depth_invalid});
			if (depth_invalid) n_invalid++;
			if (lit) n_lit++;
		end
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_point(16'h4000, 16'h8000, 16'hC000, 16'h4000);
		send_point(16'h8000, 16'h4000, 16'h4000, 16'hC000);
		send_point(16'h3FFF, 16'h7FFF, 16'hBFFF, 16'h003F);
		send_point(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		send_point(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		drain();

		// Large radii with a short viewer distance push the depth through zero.
		apply_setting(4095, 4095, 1023, 0, 2047, 2047);
		write_reg(reg_index_t'(3'd7), 13'h1FFF);
		send_point(16'h4000, 16'h0000, 16'h0000, 16'h4000);
		send_point(16'hC000, 16'h0000, 16'h0000, 16'hC000);
		send_point(16'h0000, 16'h0000, 16'h8000, 16'h0000);
		send_point(16'h4000, 16'h4000, 16'h4000, 16'h4000);
		random_run(40);
		drain();

		// Tiny depth with a large gain saturates the screen coordinates.
		apply_setting(4095, 4095, 1023, 1, 0, 0);
		send_point(16'h4000, 16'h4000, 16'h0000, 16'hC000);
		send_point(16'h0000, 16'h4000, 16'h0000, 16'h0000);
		random_run(40);
		drain();

		apply_setting(0, 0, 0, 8191, 0, 0);
		send_point(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
		random_run(20);
		drain();

		apply_setting(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
		random_run(30);
		drain();

		apply_setting(256, 512, 150, 1280, 150, 120);
		random_run(260);
		drain();

		apply_setting($urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 1023), $urandom_range(0, 8191),
			$urandom_range(0, 2047), $urandom_range(0, 2047));
		random_run(250);
		drain();

		$display("Covered %0d points over seven register settings: %0d lit, %0d behind viewer.",
			sb.checked, n_lit, n_invalid);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
